@@ hdl/las_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_pkg: shared types and constants of the local alignment score block
// Holds the scoring constants, the controller state type and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package las_pkg;

   localparam int MAX_PATTERN_DEF = 32;
   localparam int CHAR_W          = 8;
   localparam int SCORE_W         = 10;
   localparam int CALC_W          = 12;

   typedef logic signed [CALC_W-1:0] calc_type;

   localparam calc_type SCORE_MATCH    = calc_type'(16);
   localparam calc_type SCORE_MISMATCH = calc_type'(-128);
   localparam calc_type SCORE_GAP      = calc_type'(-64);
   localparam calc_type SCORE_MAX      = calc_type'(1023);

   localparam logic KIND_PATTERN = 1'b0;
   localparam logic KIND_KEYWORD = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } las_state_type;

   typedef struct packed {
      logic load;   // store a pattern character
      logic start;  // latch a keyword character and begin a column
      logic scan;   // column sweep in progress
      logic emit;   // load the result register and clear the scoring state
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic last;
      logic out_free;
   } dp_sts_type;

endpackage

@@ hdl/local_alignment_score_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_alignment_score_top: Smith-Waterman local alignment score, linear gap
// Scores streamed keyword characters against a stored pattern.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall, req_kind, req_ch, req_last)
// carries one character per beat. Pattern beats (kind 0) are stored, up to
// MAX_PATTERN characters; a pattern beat after a keyword or after a pattern
// beat marked last begins a new pattern. Keyword beats (kind 1) each compute
// one column of the score matrix. While a keyword beat is processed, requests
// are stalled: the column is swept one row per cycle through the pattern and
// column stores, whose registered reads feed the cell recurrence, and each
// cell result then updates the running best.
// When the sweep of the keyword beat marked last is done, it loads one
// response beat (rsp_score, rsp_hit, rsp_truncated), waiting while the output
// register is full; the running best and the column store are then cleared.
// The response sits in an output register, so new pattern and keyword beats
// are taken while it waits. A further result cannot be loaded until the
// previous one has left; the block stalls its requests until then.
// Synchronous reset empties the pattern, the column store and the result.
// ----------------------------------------------------------------------------
module local_alignment_score_top #(
   parameter int MAX_PATTERN = las_pkg::MAX_PATTERN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [las_pkg::CHAR_W-1:0]    req_ch,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [las_pkg::SCORE_W-1:0]   rsp_score,
   output logic                          rsp_hit,
   output logic                          rsp_truncated
);

   las_pkg::dp_cmd_type cmd;
   las_pkg::dp_sts_type sts;

   las_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   las_dp #(.MAX_PATTERN(MAX_PATTERN)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .req_last      (req_last),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_score     (rsp_score),
      .rsp_hit       (rsp_hit),
      .rsp_truncated (rsp_truncated)
   );

   // A result is only loaded when the output register can take it.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded over a waiting response");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("loaded result not presented");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> req_stall)
      else $error("request taken during a column sweep");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.start, cmd.scan}))
      else $error("conflicting datapath commands");

endmodule

@@ hdl/las_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module las_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/las_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_ctrl: sequencer of the local alignment score block
// Accepts input beats, starts the column sweep and hands results to the
// output register.
// ----------------------------------------------------------------------------
module las_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_kind,
   output logic                   req_stall,
   output las_pkg::dp_cmd_type    cmd,
   input  las_pkg::dp_sts_type    sts
);

   las_pkg::las_state_type state_ff, state_in;
   logic accept;

   assign accept = req_valid && (state_ff == las_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= las_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         las_pkg::ST_IDLE: begin
            if (accept && (req_kind == las_pkg::KIND_KEYWORD)) begin
               state_in = las_pkg::ST_SCAN;
            end
         end
         las_pkg::ST_SCAN: begin
            if (sts.scan_done) begin
               if (sts.last && !sts.out_free) begin
                  state_in = las_pkg::ST_EMIT;
               end else begin
                  state_in = las_pkg::ST_IDLE;
               end
            end
         end
         las_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               state_in = las_pkg::ST_IDLE;
            end
         end
         default: state_in = las_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         las_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = accept && (req_kind == las_pkg::KIND_PATTERN);
            cmd.start = accept && (req_kind == las_pkg::KIND_KEYWORD);
         end
         las_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            cmd.emit = sts.scan_done && sts.last && sts.out_free;
         end
         las_pkg::ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

@@ hdl/las_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_dp: datapath of the local alignment score block
// Pattern store, previous-column store, the cell recurrence and the result
// register.
// ----------------------------------------------------------------------------
module las_dp #(
   parameter int MAX_PATTERN = las_pkg::MAX_PATTERN_DEF,
   localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
   localparam int LW = $clog2(MAX_PATTERN + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [las_pkg::CHAR_W-1:0]    req_ch,
   input  logic                          req_last,
   input  las_pkg::dp_cmd_type           cmd,
   output las_pkg::dp_sts_type           sts,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [las_pkg::SCORE_W-1:0]   rsp_score,
   output logic                          rsp_hit,
   output logic                          rsp_truncated
);

   localparam int SW = las_pkg::SCORE_W;
   localparam int CW = las_pkg::CHAR_W;

   // Pattern state.
   logic [LW-1:0] length_ff, length_in;
   logic          loading_ff, loading_in;
   logic          cut_ff, cut_in;
   logic [LW-1:0] eff_len;
   logic          pat_wr;

   // Keyword character and sweep state.
   logic [CW-1:0] kw_ch_ff;
   logic          kw_last_ff;
   logic [LW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_issue;
   logic          s1_vld_ff, s1_vld_in;
   logic [AW-1:0] s1_idx_ff, s1_idx_in;
   logic [SW-1:0] diag_ff, diag_in;
   logic [SW-1:0] up_ff, up_in;
   logic [SW-1:0] best_ff, best_in;
   logic [MAX_PATTERN-1:0] col_vld_ff, col_vld_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_score_ff;
   logic          rsp_cut_ff;

   logic [CW-1:0] pat_rd;
   logic [SW-1:0] col_rd;
   logic [SW-1:0] left;
   las_pkg::calc_type c_diag, c_up, c_left, c_max;
   logic [SW-1:0] cell_score;
   logic          out_free;

   // A pattern character that arrives outside a load starts a new pattern.
   assign eff_len  = loading_ff ? length_ff : '0;
   assign pat_wr   = cmd.load && (eff_len < LW'(MAX_PATTERN));
   assign rd_issue = cmd.scan && (rd_idx_ff < length_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   las_ram #(.WIDTH(CW), .DEPTH(MAX_PATTERN)) u_pat_ram (
      .clock   (clock),
      .wr_en   (pat_wr),
      .wr_addr (eff_len[AW-1:0]),
      .wr_data (req_ch),
      .rd_en   (rd_issue),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (pat_rd)
   );

   las_ram #(.WIDTH(SW), .DEPTH(MAX_PATTERN)) u_col_ram (
      .clock   (clock),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_idx_ff),
      .wr_data (cell_score),
      .rd_en   (rd_issue),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (col_rd)
   );

   // Cell recurrence; an entry not written since the last clear reads as zero.
   always_comb begin
      left   = col_vld_ff[s1_idx_ff] ? col_rd : '0;
      c_diag = las_pkg::calc_type'({2'b00, diag_ff})
               + ((pat_rd == kw_ch_ff) ? las_pkg::SCORE_MATCH : las_pkg::SCORE_MISMATCH);
      c_up   = las_pkg::calc_type'({2'b00, up_ff}) + las_pkg::SCORE_GAP;
      c_left = las_pkg::calc_type'({2'b00, left}) + las_pkg::SCORE_GAP;
      c_max  = '0;
      if (c_diag > c_max) begin
         c_max = c_diag;
      end
      if (c_up > c_max) begin
         c_max = c_up;
      end
      if (c_left > c_max) begin
         c_max = c_left;
      end
      cell_score = (c_max > las_pkg::SCORE_MAX) ? SW'(las_pkg::SCORE_MAX)
                                                : c_max[SW-1:0];
   end

   always_comb begin
      length_in    = length_ff;
      loading_in   = loading_ff;
      cut_in       = cut_ff;
      rd_idx_in    = rd_idx_ff;
      s1_vld_in    = 1'b0;
      s1_idx_in    = s1_idx_ff;
      diag_in      = diag_ff;
      up_in        = up_ff;
      best_in      = best_ff;
      col_vld_in   = col_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         loading_in = !req_last;
         if (!loading_ff) begin
            cut_in     = 1'b0;
            best_in    = '0;
            col_vld_in = '0;
         end
         if (pat_wr) begin
            length_in = eff_len + LW'(1);
         end else begin
            length_in = eff_len;
            cut_in    = 1'b1;
         end
      end

      if (cmd.start) begin
         loading_in = 1'b0;
         rd_idx_in  = '0;
         diag_in    = '0;
         up_in      = '0;
      end

      if (rd_issue) begin
         rd_idx_in = rd_idx_ff + LW'(1);
         s1_vld_in = 1'b1;
         s1_idx_in = rd_idx_ff[AW-1:0];
      end

      if (s1_vld_ff) begin
         diag_in               = left;
         up_in                 = cell_score;
         col_vld_in[s1_idx_ff] = 1'b1;
         if (cell_score > best_ff) begin
            best_in = cell_score;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         best_in      = '0;
         col_vld_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         loading_ff   <= 1'b0;
         cut_ff       <= 1'b0;
         s1_vld_ff    <= 1'b0;
         best_ff      <= '0;
         col_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         loading_ff   <= loading_in;
         cut_ff       <= cut_in;
         s1_vld_ff    <= s1_vld_in;
         best_ff      <= best_in;
         col_vld_ff   <= col_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      s1_idx_ff <= s1_idx_in;
      diag_ff   <= diag_in;
      up_ff     <= up_in;
      if (cmd.start) begin
         kw_ch_ff   <= req_ch;
         kw_last_ff <= req_last;
      end
      if (cmd.emit) begin
         rsp_score_ff <= best_ff;
         rsp_cut_ff   <= cut_ff;
      end
   end

   assign sts.scan_done = (rd_idx_ff == length_ff) && !s1_vld_ff;
   assign sts.last      = kw_last_ff;
   assign sts.out_free  = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_score     = rsp_score_ff;
   assign rsp_hit       = (rsp_score_ff != '0);
   assign rsp_truncated = rsp_cut_ff;

endmodule
